FILE: sv/lswc_pkg.sv
package lswc_pkg;

    localparam int CW = 16;

    localparam logic [3:0] CODE_BOTTOM = 4'h8;
    localparam logic [3:0] CODE_TOP    = 4'h4;
    localparam logic [3:0] CODE_RIGHT  = 4'h2;
    localparam logic [3:0] CODE_LEFT   = 4'h1;

    localparam int MAX_CLIP_STEPS = 8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] start_x_in;
        logic signed [CW-1:0] start_y_in;
        logic signed [CW-1:0] end_x_in;
        logic signed [CW-1:0] end_y_in;
    } t_seg_in;

    typedef struct packed {
        logic signed [CW-1:0] start_x_out;
        logic signed [CW-1:0] start_y_out;
        logic signed [CW-1:0] end_x_out;
        logic signed [CW-1:0] end_y_out;
        logic                 visible;
    } t_seg_out;

    // Window edges widened by one bit so right and bottom never wrap.
    typedef struct packed {
        logic signed [CW:0] left;
        logic signed [CW:0] top;
        logic signed [CW:0] right;
        logic signed [CW:0] bottom;
    } t_window;

    // Classified item handed from the front end to the clip engine.
    typedef struct packed {
        t_seg_in    seg;
        logic [3:0] code1;
        logic [3:0] code2;
    } t_job;

    function automatic logic [3:0] outcode(input logic signed [CW:0] x,
                                           input logic signed [CW:0] y,
                                           input t_window w);
        logic [3:0] c;
        c = 4'h0;
        if (y > w.bottom) begin
            c = c | CODE_BOTTOM;
        end else if (y < w.top) begin
            c = c | CODE_TOP;
        end
        if (x > w.right) begin
            c = c | CODE_RIGHT;
        end else if (x < w.left) begin
            c = c | CODE_LEFT;
        end
        return c;
    endfunction

endpackage

FILE: sv/lswc_front.sv
module lswc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lswc_pkg::t_seg_in i_seg,
    input  lswc_pkg::t_window i_win,
    output logic             o_full,
    output logic             o_job_valid,
    output lswc_pkg::t_job   o_job,
    input  logic             i_job_take
);

    // Two-entry queue of classified segments.
    lswc_pkg::t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push;
    lswc_pkg::t_job job;

    always_comb begin
        job.seg   = i_seg;
        job.code1 = lswc_pkg::outcode({i_seg.start_x_in[lswc_pkg::CW-1], i_seg.start_x_in},
                                      {i_seg.start_y_in[lswc_pkg::CW-1], i_seg.start_y_in},
                                      i_win);
        job.code2 = lswc_pkg::outcode({i_seg.end_x_in[lswc_pkg::CW-1], i_seg.end_x_in},
                                      {i_seg.end_y_in[lswc_pkg::CW-1], i_seg.end_y_in},
                                      i_win);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign push        = i_start && !o_full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_job_take && o_job_valid) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_job_take && o_job_valid};
        end
    end

    property p_take_needs_entry;
        @(posedge i_clk) disable iff (!i_rst_n) i_job_take |-> r_cnt != 2'd0;
    endproperty
    a_take_needs_entry: assert property (p_take_needs_entry)
        else $error("queue read while empty");

    property p_cnt_bounded;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2;
    endproperty
    a_cnt_bounded: assert property (p_cnt_bounded)
        else $error("queue count out of range");

    property p_full_has_entries;
        @(posedge i_clk) disable iff (!i_rst_n) o_full |-> o_job_valid;
    endproperty
    a_full_has_entries: assert property (p_full_has_entries)
        else $error("queue full but nothing valid");

endmodule

FILE: sv/lswc_div.sv
module lswc_div #(
    parameter int NW = 34,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    // Restoring divider, one quotient bit per cycle.
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_q;
    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;

    assign shifted = {r_rem[DW-1:0], r_q[NW-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_quo   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                if (!diff[DW]) begin
                    r_rem <= diff;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/lswc_engine.sv
module lswc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  lswc_pkg::t_job    i_job,
    input  lswc_pkg::t_window i_win,
    output logic              o_job_take,
    output logic              o_idle,
    output logic              o_valid,
    output lswc_pkg::t_seg_out o_res
);

    localparam int CW = lswc_pkg::CW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TEST = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;

    logic [2:0] r_st;
    logic signed [CW:0] r_x1, r_y1, r_x2, r_y2;
    logic [3:0] r_c1, r_c2;
    logic [3:0] r_steps;
    logic       r_horiz;  // crossing with top or bottom edge
    logic signed [CW+1:0] r_num, r_mul, r_den;
    logic signed [CW:0] r_edge;
    logic [2*CW+3:0] r_prod;
    logic       r_neg;
    logic       r_div_go;
    logic       div_done;
    logic [2*CW+3:0] div_quo;
    logic [3:0] c;
    logic signed [CW+1:0] sdiff_n, sdiff_m, sdiff_d;
    logic [CW+1:0] ad;
    logic signed [2*CW+4:0] sq;
    logic signed [CW:0] nx, ny, offs;

    assign o_idle     = (r_st == ST_IDLE) && !i_job_valid;
    assign o_job_take = (r_st == ST_IDLE) && i_job_valid;
    assign c          = (r_c1 != 4'h0) ? r_c1 : r_c2;

    always_comb begin
        if ((c & (lswc_pkg::CODE_BOTTOM | lswc_pkg::CODE_TOP)) != 4'h0) begin
            sdiff_n = {r_edge[CW], r_edge} - {r_y1[CW], r_y1};
            sdiff_m = {r_x2[CW], r_x2} - {r_x1[CW], r_x1};
            sdiff_d = {r_y2[CW], r_y2} - {r_y1[CW], r_y1};
        end else begin
            sdiff_n = {r_edge[CW], r_edge} - {r_x1[CW], r_x1};
            sdiff_m = {r_y2[CW], r_y2} - {r_y1[CW], r_y1};
            sdiff_d = {r_x2[CW], r_x2} - {r_x1[CW], r_x1};
        end
    end

    assign ad = r_den[CW+1] ? (CW+2)'(0) - r_den : r_den;

    lswc_div #(.NW(2*CW+4), .DW(CW+2)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  (r_prod),
        .i_den  (ad),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign sq    = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign offs  = (ad == '0) ? '0 : sq[CW:0];
    assign nx    = r_horiz ? r_x1 + offs : r_edge;
    assign ny    = r_horiz ? r_edge : r_y1 + offs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_x1 <= {i_job.seg.start_x_in[CW-1], i_job.seg.start_x_in};
                        r_y1 <= {i_job.seg.start_y_in[CW-1], i_job.seg.start_y_in};
                        r_x2 <= {i_job.seg.end_x_in[CW-1], i_job.seg.end_x_in};
                        r_y2 <= {i_job.seg.end_y_in[CW-1], i_job.seg.end_y_in};
                        r_c1 <= i_job.code1;
                        r_c2 <= i_job.code2;
                        r_steps <= 4'd0;
                        r_st <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if ((r_c1 | r_c2) == 4'h0 || (r_c1 & r_c2) != 4'h0
                        || r_steps == 4'(lswc_pkg::MAX_CLIP_STEPS)) begin
                        o_valid <= 1'b1;
                        o_res.start_x_out <= r_x1[CW-1:0];
                        o_res.start_y_out <= r_y1[CW-1:0];
                        o_res.end_x_out   <= r_x2[CW-1:0];
                        o_res.end_y_out   <= r_y2[CW-1:0];
                        o_res.visible     <= ((r_c1 | r_c2) == 4'h0);
                        r_st <= ST_IDLE;
                    end else begin
                        r_steps <= r_steps + 4'd1;
                        r_horiz <= (c & (lswc_pkg::CODE_BOTTOM | lswc_pkg::CODE_TOP)) != 4'h0;
                        if ((c & lswc_pkg::CODE_BOTTOM) != 4'h0) begin
                            r_edge <= i_win.bottom;
                        end else if ((c & lswc_pkg::CODE_TOP) != 4'h0) begin
                            r_edge <= i_win.top;
                        end else if ((c & lswc_pkg::CODE_RIGHT) != 4'h0) begin
                            r_edge <= i_win.right;
                        end else begin
                            r_edge <= i_win.left;
                        end
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_num <= sdiff_n;
                    r_mul <= sdiff_m;
                    r_den <= sdiff_d;
                    r_st  <= ST_DIV;
                end
                ST_DIV: begin
                    r_neg <= (r_num[CW+1] ^ r_mul[CW+1]) ^ r_den[CW+1];
                    r_prod <= (2*CW+4)'((r_num[CW+1] ? -r_num : r_num))
                            * (2*CW+4)'((r_mul[CW+1] ? -r_mul : r_mul));
                    r_div_go <= 1'b1;
                    r_st <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        r_st <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_c1 != 4'h0) begin
                        r_x1 <= nx;
                        r_y1 <= ny;
                        r_c1 <= lswc_pkg::outcode(nx, ny, i_win);
                    end else begin
                        r_x2 <= nx;
                        r_y2 <= ny;
                        r_c2 <= lswc_pkg::outcode(nx, ny, i_win);
                    end
                    r_st <= ST_TEST;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    property p_div_only_when_waiting;
        @(posedge i_clk) disable iff (!i_rst_n) div_done |-> r_st == ST_WAIT;
    endproperty
    a_div_only_when_waiting: assert property (p_div_only_when_waiting)
        else $error("divider finished outside wait");

    property p_result_returns_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> r_st == ST_IDLE;
    endproperty
    a_result_returns_idle: assert property (p_result_returns_idle)
        else $error("result without return to idle");

    property p_steps_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_st == ST_MUL |-> r_steps <= 4'(lswc_pkg::MAX_CLIP_STEPS);
    endproperty
    a_steps_bounded: assert property (p_steps_bounded)
        else $error("too many clip steps");

endmodule

FILE: sv/line_segment_window_clip.sv
// Flow: with the engine idle, a segment that needs no clip step is queued,
// taken by the engine from idle, tested, and its result word registered on the
// ports; each clip step adds the setup, product, wait and update states, the
// wait spent on the bit-serial divider. Throughput: one segment at a time in
// the clip engine, at most 8 clip steps; a two-word queue takes start meanwhile.
// Reset: synchronous, active low; window registers clear to zero.
// Here the receiver cannot stall: each result word shows for one cycle.
module line_segment_window_clip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lswc_pkg::t_seg_in   i_seg,
    output logic                o_done,
    output lswc_pkg::t_seg_out  o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [lswc_pkg::CW-1:0] i_cfg_data
);

    // Window registers. The right and bottom edges are precomputed one
    // bit wider so the comparisons never wrap.
    logic signed [lswc_pkg::CW-1:0] r_left, r_top;
    logic [lswc_pkg::CW-2:0]        r_width, r_height;
    lswc_pkg::t_window             win;
    logic                          full;
    logic                          job_valid;
    logic                          job_take;
    logic                          idle;
    lswc_pkg::t_job                job;

    assign o_cfg_ready = 1'b1;
    assign busy        = full;

    assign win.left   = {r_left[lswc_pkg::CW-1], r_left};
    assign win.top    = {r_top[lswc_pkg::CW-1], r_top};
    assign win.right  = {r_left[lswc_pkg::CW-1], r_left} + {2'b00, r_width};
    assign win.bottom = {r_top[lswc_pkg::CW-1], r_top} + {2'b00, r_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lswc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                lswc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                lswc_pkg::REG_WIDTH:  r_width  <= i_cfg_data[lswc_pkg::CW-2:0];
                lswc_pkg::REG_HEIGHT: r_height <= i_cfg_data[lswc_pkg::CW-2:0];
                default: ;
            endcase
        end
    end

    // The front end classifies each word and queues it.
    lswc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_seg      (i_seg),
        .i_win      (win),
        .o_full     (full),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_take (job_take)
    );

    // The engine runs the clip loop with one shared divider.
    lswc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job      (job),
        .i_win      (win),
        .o_job_take (job_take),
        .o_idle     (idle),
        .o_valid    (o_done),
        .o_res      (o_res)
    );

    property p_take_needs_job;
        @(posedge i_clk) disable iff (!i_rst_n) job_take |-> job_valid;
    endproperty
    a_take_needs_job: assert property (p_take_needs_job)
        else $error("engine took from empty queue");

    property p_idle_not_busy;
        @(posedge i_clk) disable iff (!i_rst_n) idle |-> !busy;
    endproperty
    a_idle_not_busy: assert property (p_idle_not_busy)
        else $error("busy while idle");

    property p_done_one_cycle;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done;
    endproperty
    a_done_one_cycle: assert property (p_done_one_cycle)
        else $error("result strobe longer than one cycle");

endmodule
